FILE: rtl/key_debounce_accelerating_repeat_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key debounce block
// Concurrent checks that vanish when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_ACCELERATING_REPEAT_DEFINES_SVH
`define KEY_DEBOUNCE_ACCELERATING_REPEAT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expr must hold on every clock outside reset
`define KDAR_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define KDAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define KDAR_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define KDAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/kdar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_pkg
// Shared constants, register codes and types of the key debounce block.
// ----------------------------------------------------------------------------
package kdar_pkg;

   localparam int KEY_COUNT   = 4;
   localparam int STAGE_COUNT = 5;

   localparam int KEY_W      = 4;
   localparam int DEBOUNCE_W = 16;
   localparam int WAIT_W     = 8;
   localparam int STAGE_W    = 3;
   localparam int EMIT_W     = 8;
   localparam int WAITS_W    = 40;
   localparam int REPEATS_W  = 32;
   localparam int CSR_DATA_W = 40;
   localparam int CSR_IDX_W  = 2;

   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_COUNT >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_COUNT) - 1);

   localparam logic [STAGE_W-1:0] FINAL_STAGE = STAGE_W'(STAGE_COUNT - 1);
   localparam logic [WAIT_W-1:0]  WAIT_MAX    = {WAIT_W{1'b1}};
   localparam logic [EMIT_W-1:0]  EMIT_MAX    = {EMIT_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_CEILING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_WAITS        = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_REPEATS      = 2'd3;

   localparam logic [DEBOUNCE_W-1:0] THRESHOLD_RESET = 16'd10;
   localparam logic [DEBOUNCE_W-1:0] CEILING_RESET   = 16'hFFFF;
   localparam logic [WAITS_W-1:0]    WAITS_RESET     = 40'h00_0207_1400;
   localparam logic [REPEATS_W-1:0]  REPEATS_RESET   = 32'h0A05_0101;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] threshold;
      logic [DEBOUNCE_W-1:0] ceiling;
      logic [WAITS_W-1:0]    waits;
      logic [REPEATS_W-1:0]  repeats;
   } cfg_type;

   // byte of a packed per-stage table, zero past the table end
   function automatic logic [7:0] stage_byte(input logic [63:0] packed_bytes,
                                             input logic [STAGE_W-1:0] stage,
                                             input int nbytes);
      logic [7:0] result;
      result = 8'd0;
      if (int'(stage) < nbytes) begin
         result = packed_bytes[8*stage +: 8];
      end
      return result;
   endfunction

endpackage

FILE: rtl/kdar_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_csr
// Configuration registers of the key debounce block.
// ----------------------------------------------------------------------------
module kdar_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [kdar_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kdar_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output kdar_pkg::cfg_type                 cfg
);

   kdar_pkg::cfg_type cfg_ff;
   kdar_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            kdar_pkg::CSR_DEBOUNCE_THRESHOLD: begin
               cfg_in.threshold = csr_write_data[kdar_pkg::DEBOUNCE_W-1:0];
            end
            kdar_pkg::CSR_DEBOUNCE_CEILING: begin
               cfg_in.ceiling = csr_write_data[kdar_pkg::DEBOUNCE_W-1:0];
            end
            kdar_pkg::CSR_STAGE_WAITS: begin
               cfg_in.waits = csr_write_data[kdar_pkg::WAITS_W-1:0];
            end
            kdar_pkg::CSR_STAGE_REPEATS: begin
               cfg_in.repeats = csr_write_data[kdar_pkg::REPEATS_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= kdar_pkg::THRESHOLD_RESET;
         cfg_ff.ceiling   <= kdar_pkg::CEILING_RESET;
         cfg_ff.waits     <= kdar_pkg::WAITS_RESET;
         cfg_ff.repeats   <= kdar_pkg::REPEATS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/kdar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_core
// Debounce, wait and repeat-stage state with the per-tick update logic.
// ----------------------------------------------------------------------------
`include "key_debounce_accelerating_repeat_defines.svh"

module kdar_core (
   input  logic                          clock,
   input  logic                          reset,
   input  kdar_pkg::cfg_type             cfg,
   input  logic                          step,
   input  logic [kdar_pkg::KEY_W-1:0]    keys_raw,
   output logic [kdar_pkg::KEY_W-1:0]    key_event
);

   logic [kdar_pkg::KEY_W-1:0]      prev_keys_ff, prev_keys_in;
   logic [kdar_pkg::DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [kdar_pkg::WAIT_W-1:0]     wait_ff, wait_in;
   logic [kdar_pkg::STAGE_W-1:0]    stage_ff, stage_in;
   logic [kdar_pkg::EMIT_W-1:0]     emits_ff, emits_in;
   logic                            emitted_ff, emitted_in;

   logic [kdar_pkg::KEY_W-1:0]      keys;
   logic [7:0]                      wait_limit;
   logic [7:0]                      repeat_limit;
   logic [kdar_pkg::EMIT_W-1:0]     emits_next;

   always_comb begin
      keys         = keys_raw & kdar_pkg::KEY_MASK;
      prev_keys_in = keys;
      debounce_in  = debounce_ff;
      wait_in      = wait_ff;
      stage_in     = stage_ff;
      emits_in     = emits_ff;
      emitted_in   = emitted_ff;
      key_event    = '0;
      emits_next   = '0;

      if ((keys != '0) && (keys == prev_keys_ff)) begin
         if (debounce_ff < cfg.ceiling) begin
            debounce_in = debounce_ff + 1'b1;
         end
      end else if ((keys != prev_keys_ff) && emitted_ff) begin
         // new pattern after an event restarts the repeat sequence
         emitted_in  = 1'b0;
         debounce_in = '0;
         stage_in    = '0;
         emits_in    = '0;
      end

      wait_limit   = kdar_pkg::stage_byte(64'(cfg.waits), stage_in, kdar_pkg::STAGE_COUNT);
      repeat_limit = kdar_pkg::stage_byte(64'(cfg.repeats), stage_in,
                                          kdar_pkg::STAGE_COUNT - 1);

      if (debounce_in > cfg.threshold) begin
         debounce_in = '0;
         if (wait_ff >= wait_limit) begin
            if (stage_in < kdar_pkg::FINAL_STAGE) begin
               emits_next = (emits_in < kdar_pkg::EMIT_MAX) ? emits_in + 1'b1 : emits_in;
               if (emits_next >= repeat_limit) begin
                  stage_in = stage_in + 1'b1;
                  emits_in = '0;
               end else begin
                  emits_in = emits_next;
               end
            end
            emitted_in = 1'b1;
            wait_in    = '0;
            key_event  = keys;
         end else if (wait_ff < kdar_pkg::WAIT_MAX) begin
            wait_in = wait_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
         debounce_ff  <= '0;
         wait_ff      <= '0;
         stage_ff     <= '0;
         emits_ff     <= '0;
         emitted_ff   <= 1'b0;
      end else if (step) begin
         prev_keys_ff <= prev_keys_in;
         debounce_ff  <= debounce_in;
         wait_ff      <= wait_in;
         stage_ff     <= stage_in;
         emits_ff     <= emits_in;
         emitted_ff   <= emitted_in;
      end
   end

   `KDAR_ASSERT_ALWAYS(a_stage_bound, clock, reset, stage_ff <= kdar_pkg::FINAL_STAGE, "stage past final")
   `KDAR_ASSERT_ALWAYS(a_final_no_emits, clock, reset, (stage_ff != kdar_pkg::FINAL_STAGE) || (emits_ff == '0), "final stage keeps emissions")
   `KDAR_ASSERT_NEXT(a_event_marks, clock, reset, step && (key_event != '0), emitted_ff && (wait_ff == '0), "event did not mark state")

endmodule

FILE: rtl/key_debounce_accelerating_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_accelerating_repeat
// Keypad debounce with accelerating auto-repeat over several repeat stages.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                     | word
//  req     | in        | req_valid req_stall req_key_bits          | one sample tick
//  rsp     | out       | rsp_valid rsp_stall rsp_key_event         | one event (0 = none)
//  csr     | in        | csr_write_enable csr_index csr_write_data | one register write
//
//  One word per cycle sustained while rsp is not stalled; a word passes
//  the input register, then the state update into the result register.
//  Reset is synchronous, clears the valid flags and core state and loads register defaults.
//  A stalled rsp holds the result; the input register waits behind it and
//  req_stall rises only when both are full.
// ----------------------------------------------------------------------------
`include "key_debounce_accelerating_repeat_defines.svh"

module key_debounce_accelerating_repeat (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kdar_pkg::KEY_W-1:0]        req_key_bits,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kdar_pkg::KEY_W-1:0]        rsp_key_event,
   input  logic                              csr_write_enable,
   input  logic [kdar_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kdar_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   kdar_pkg::cfg_type              cfg;
   logic                           in_valid_ff;
   logic [kdar_pkg::KEY_W-1:0]     in_keys_ff;
   logic                           out_valid_ff;
   logic [kdar_pkg::KEY_W-1:0]     out_event_ff;
   logic [kdar_pkg::KEY_W-1:0]     event_in;
   logic                           out_free;
   logic                           step;
   logic                           req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   kdar_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   kdar_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .keys_raw  (in_keys_ff),
      .key_event (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_keys_ff <= req_key_bits;
      end
      if (step) begin
         out_event_ff <= event_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_event = out_event_ff;

   `KDAR_ASSERT_ALWAYS(a_stall_means_full, clock, reset,
                       !req_stall || (in_valid_ff && out_valid_ff),
                       "req stalled with free slot")
   `KDAR_ASSERT_NEXT(a_step_fills_out, clock, reset, step, out_valid_ff, "processed word lost")

endmodule

FILE: dv/kdar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdar_checker
// Watches the sample, event and register ports of the key debounce block,
// keeps its own copy of the debounce and repeat state, predicts the event for
// every accepted sample word and compares it with each accepted event word.
// ----------------------------------------------------------------------------
module kdar_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [kdar_pkg::KEY_W-1:0]      req_key_bits,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [kdar_pkg::KEY_W-1:0]      rsp_key_event,
   input  logic                            csr_write_enable,
   input  logic [kdar_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdar_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                              fail_count,
   output int                              outstanding
);

   // register copies
   logic [kdar_pkg::DEBOUNCE_W-1:0] threshold_q;
   logic [kdar_pkg::DEBOUNCE_W-1:0] ceiling_q;
   logic [kdar_pkg::WAITS_W-1:0]    waits_q;
   logic [kdar_pkg::REPEATS_W-1:0]  repeats_q;

   // debounce and repeat state
   logic [kdar_pkg::KEY_W-1:0]      last_keys;
   logic [kdar_pkg::DEBOUNCE_W-1:0] settle_count;
   logic [kdar_pkg::WAIT_W-1:0]     wait_periods;
   logic [kdar_pkg::STAGE_W-1:0]    stage;
   logic [kdar_pkg::EMIT_W-1:0]     stage_fires;
   logic                            fired;

   logic [kdar_pkg::KEY_W-1:0]      pending_events[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what,
                                  input logic [kdar_pkg::KEY_W-1:0] got,
                                  input logic [kdar_pkg::KEY_W-1:0] want);
      fail_count++;
      if (fail_count <= 100) begin
         $display("ERROR %0t ns: %s: key_event got %h, want %h", $time, what, got, want);
      end
   endtask

   function automatic logic [kdar_pkg::KEY_W-1:0] next_key_event(
         input logic [kdar_pkg::KEY_W-1:0] sample);
      logic [kdar_pkg::KEY_W-1:0] keys;
      logic [kdar_pkg::KEY_W-1:0] result;
      keys   = sample & kdar_pkg::KEY_MASK;
      result = '0;
      if (keys != '0 && keys == last_keys) begin
         if (settle_count < ceiling_q) begin
            settle_count++;
         end
      end else if (keys != last_keys && fired) begin
         // new keys after a fire restart the typematic sequence; wait count stays
         fired        = 1'b0;
         settle_count = '0;
         stage        = '0;
         stage_fires  = '0;
      end
      last_keys = keys;

      if (settle_count > threshold_q) begin
         settle_count = '0;
         if (wait_periods >= waits_q[8*stage +: 8]) begin
            if (stage < kdar_pkg::FINAL_STAGE) begin
               if (stage_fires < kdar_pkg::EMIT_MAX) begin
                  stage_fires++;
               end
               if (stage_fires >= repeats_q[8*stage +: 8]) begin
                  stage++;
                  stage_fires = '0;
               end
            end
            fired        = 1'b1;
            wait_periods = '0;
            result       = keys;
         end else if (wait_periods < kdar_pkg::WAIT_MAX) begin
            wait_periods++;
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      logic [kdar_pkg::KEY_W-1:0] want;
      if (reset) begin
         threshold_q  = kdar_pkg::THRESHOLD_RESET;
         ceiling_q    = kdar_pkg::CEILING_RESET;
         waits_q      = kdar_pkg::WAITS_RESET;
         repeats_q    = kdar_pkg::REPEATS_RESET;
         last_keys    = '0;
         settle_count = '0;
         wait_periods = '0;
         stage        = '0;
         stage_fires  = '0;
         fired        = 1'b0;
         pending_events.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               kdar_pkg::CSR_DEBOUNCE_THRESHOLD:
                  threshold_q = csr_write_data[kdar_pkg::DEBOUNCE_W-1:0];
               kdar_pkg::CSR_DEBOUNCE_CEILING:
                  ceiling_q   = csr_write_data[kdar_pkg::DEBOUNCE_W-1:0];
               kdar_pkg::CSR_STAGE_WAITS:
                  waits_q     = csr_write_data[kdar_pkg::WAITS_W-1:0];
               kdar_pkg::CSR_STAGE_REPEATS:
                  repeats_q   = csr_write_data[kdar_pkg::REPEATS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               report_mismatch("event word with none pending", rsp_key_event, '0);
            end else begin
               want = pending_events.pop_front();
               if (rsp_key_event !== want) begin
                  report_mismatch("event word mismatch", rsp_key_event, want);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_events.push_back(next_key_event(req_key_bits));
         end
      end
      outstanding = pending_events.size();
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample words into the key debounce block under a series of register
// settings (reset values, fire-every-tick, long stage tables, settings that
// never fire, random small tables) with random idle gaps and output stalls,
// and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;

   localparam int KEY_W      = kdar_pkg::KEY_W;
   localparam int CSR_IDX_W  = kdar_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = kdar_pkg::CSR_DATA_W;
   localparam int DEBOUNCE_W = kdar_pkg::DEBOUNCE_W;
   localparam int WAITS_W    = kdar_pkg::WAITS_W;
   localparam int REPEATS_W  = kdar_pkg::REPEATS_W;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int HOLD_OFF_TICKS = 80;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KEY_W-1:0]      req_key_bits;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [KEY_W-1:0]      rsp_key_event;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   int fail_count;
   int outstanding;
   int cycle_count;

   bit tx_quiet;
   bit rx_quiet;
   bit hold_off_req;

   key_debounce_accelerating_repeat DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_bits     (req_key_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_event    (rsp_key_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   kdar_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_bits     (req_key_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_event    (rsp_key_event),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // event side: random stall runs, quiet stretches, and one long hold-off
   initial begin
      int stall_left;
      int free_left;
      int hold_off_left;
      int r;
      bit hold_off_seen;
      stall_left    = 0;
      free_left     = 0;
      hold_off_left = 0;
      hold_off_seen = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_seen) begin
            hold_off_seen = 1'b1;
            hold_off_left = HOLD_OFF_TICKS;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall = 1'b1;
         end else if (rx_quiet) begin
            rsp_stall = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               free_left = $urandom_range(0, 30);
               rsp_stall = 1'b0;
            end else if (r < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall  = 1'b1;
            end else begin
               stall_left = $urandom_range(10, 40);
               rsp_stall  = 1'b1;
            end
         end
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_quiet || r < 70) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_tick(input logic [KEY_W-1:0] keys);
      int idle;
      idle = sender_gap();
      if (idle > 0) begin
         req_valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_key_bits = keys;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_hold(input logic [KEY_W-1:0] keys, input int count);
      repeat (count) send_tick(keys);
   endtask

   // mostly held patterns of random length, some per-tick noise
   task automatic run_random(input int budget, input int hold_max);
      int sent;
      int n;
      int r;
      logic [KEY_W-1:0] pattern;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            pattern = (r < 8) ? '0 : KEY_W'($urandom_range(1, 15));
            n = $urandom_range(1, hold_max);
            if (n > budget - sent) n = budget - sent;
            send_hold(pattern, n);
         end else begin
            n = $urandom_range(1, 6);
            if (n > budget - sent) n = budget - sent;
            repeat (n) send_tick(KEY_W'($urandom_range(0, 15)));
         end
         sent += n;
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   task automatic write_config(input logic [DEBOUNCE_W-1:0] threshold,
                               input logic [DEBOUNCE_W-1:0] ceiling,
                               input logic [WAITS_W-1:0] waits,
                               input logic [REPEATS_W-1:0] repeats);
      csr_write_enable = 1'b1;
      csr_index        = kdar_pkg::CSR_DEBOUNCE_THRESHOLD;
      csr_write_data   = CSR_DATA_W'(threshold);
      @(negedge clock);
      csr_index        = kdar_pkg::CSR_DEBOUNCE_CEILING;
      csr_write_data   = CSR_DATA_W'(ceiling);
      @(negedge clock);
      csr_index        = kdar_pkg::CSR_STAGE_WAITS;
      csr_write_data   = CSR_DATA_W'(waits);
      @(negedge clock);
      csr_index        = kdar_pkg::CSR_STAGE_REPEATS;
      csr_write_data   = CSR_DATA_W'(repeats);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin
      logic [DEBOUNCE_W-1:0] threshold;
      logic [DEBOUNCE_W-1:0] ceiling;
      logic [WAITS_W-1:0]    waits;
      logic [REPEATS_W-1:0]  repeats;
      logic [KEY_W-1:0]      directed_keys[$];

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_key_bits     = '0;
      csr_write_enable = 1'b0;
      csr_index        = kdar_pkg::CSR_DEBOUNCE_THRESHOLD;
      csr_write_data   = '0;
      tx_quiet         = 1'b0;
      rx_quiet         = 1'b0;
      hold_off_req     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: released keys, all-ones, key change before any fire
      directed_keys = {4'h0, 4'h0, 4'hF, 4'hF, 4'h1, 4'h1, 4'h8, 4'h0, 4'h0, 4'h5};
      foreach (directed_keys[i]) send_tick(directed_keys[i]);
      // long enough at threshold 10 and stage-1 wait 20 to fire
      send_hold(4'hA, 280);
      run_random(320, 300);
      drain();

      // fire on every stable tick; zero repeats advance each stage at once
      write_config('0, '1, '0, '0);
      directed_keys = {4'hF, 4'hF, 4'hF, 4'h3, 4'h3, 4'h3, 4'h0, 4'h0,
                       4'h8, 4'h8, 4'h8, 4'h1, 4'h2, 4'h4, 4'h4};
      foreach (directed_keys[i]) send_tick(directed_keys[i]);
      // receiver holds off while the sender keeps offering words back to back
      tx_quiet     = 1'b1;
      hold_off_req = 1'b1;
      run_random(120, 12);
      tx_quiet     = 1'b0;
      drain();

      // 255 fires in stage 0, then one per stage, then a 255-period wait in the last
      write_config('0, '1, 40'hFF_0000_0000, 32'h0101_01FF);
      send_hold(4'h6, 530);
      drain();

      // threshold at the ceiling, then a zero ceiling: nothing ever fires
      write_config('1, '1, {$urandom, 8'($urandom)}, $urandom);
      run_random(40, 30);
      drain();
      write_config('0, '0, '1, '1);
      run_random(40, 30);
      drain();

      for (int p = 0; p < 6; p++) begin
         threshold = DEBOUNCE_W'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 70) begin
            ceiling = threshold + DEBOUNCE_W'($urandom_range(1, 6));
         end else begin
            ceiling = DEBOUNCE_W'($urandom_range(0, 65535));
         end
         for (int b = 0; b < 5; b++) waits[8*b +: 8] = 8'($urandom_range(0, 3));
         for (int b = 0; b < 4; b++) repeats[8*b +: 8] = 8'($urandom_range(0, 3));
         tx_quiet = (p == 2);
         rx_quiet = (p == 4);
         write_config(threshold, ceiling, waits, repeats);
         run_random(80, 14);
         drain();
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;

      req_valid = 1'b0;
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
